// ===== sv/lvm_pkg.sv =====
// ----------------------------------------------------------------------------
// Look-at view matrix package
// Shared formats, beat types and saturation and rounding helpers for the view matrix unit.
// ----------------------------------------------------------------------------
package lvm_pkg;

	localparam int DIR_FRAC_BITS = 14;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] look_x;
		logic signed [15:0] look_y;
		logic signed [15:0] look_z;
		logic signed [15:0] up_x;
		logic signed [15:0] up_y;
		logic signed [15:0] up_z;
	} lvm_vec_t;

	typedef struct packed {
		logic signed [15:0] right_x;
		logic signed [15:0] right_y;
		logic signed [15:0] right_z;
		logic signed [15:0] perp_up_x;
		logic signed [15:0] perp_up_y;
		logic signed [15:0] perp_up_z;
		logic signed [15:0] back_x;
		logic signed [15:0] back_y;
		logic signed [15:0] back_z;
		logic signed [31:0] trans_x;
		logic signed [31:0] trans_y;
		logic signed [31:0] trans_z;
	} lvm_mat_t;

	function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
		if (v > 64'sd32767) begin
			return 16'sh7fff;
		end else if (v < -64'sd32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > 64'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	function automatic logic signed [63:0] rnd_shr(input logic signed [63:0] v);
		return (v + (64'sd1 <<< (DIR_FRAC_BITS - 1))) >>> DIR_FRAC_BITS;
	endfunction

endpackage

// ===== sv/look_at_view_matrix.sv =====
// ----------------------------------------------------------------------------
// Look-at view matrix
// Builds the world-to-camera rotation rows and translation from a camera
// position, a look direction and an up hint.
// ----------------------------------------------------------------------------
// The unit takes one beat per clock while not stalled, with up to one beat in
// flight in each pipeline stage. The pipeline depth comes from the 21-step
// square root of the normalization, done three steps per stage, and the
// 15-bit divide of the three components, also three steps per stage. A stall
// on the matrix side holds the whole pipeline and shows on the vector side in
// the same cycle. When look and up are parallel, the right row, the
// perpendicular up row and the first two translations are zero.
module look_at_view_matrix import lvm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     vec_valid,
	output logic     vec_stall,
	input  lvm_vec_t vec,
	output logic     mat_valid,
	input  logic     mat_stall,
	output lvm_mat_t mat
);

	localparam int NORM_BITS = 20;
	localparam int ROOT_BITS = 21;
	localparam int SQ_PER    = 3;
	localparam int SQ_STG    = (ROOT_BITS + SQ_PER - 1) / SQ_PER;
	localparam int RAD_W     = 2 * SQ_STG * SQ_PER;
	localparam int REM_W     = ROOT_BITS + 4;
	localparam int QB        = DIR_FRAC_BITS + 1;
	localparam int DIV_PER   = 3;
	localparam int DIV_STG   = (QB + DIV_PER - 1) / DIV_PER;
	localparam int DIV_BITS  = DIV_STG * DIV_PER;
	localparam int NUM_W     = NORM_BITS + DIR_FRAC_BITS + 1;
	localparam int DREM_W    = ROOT_BITS + 1;
	localparam int NSTG      = 5 + (SQ_STG + 1) + (DIV_STG + 1) + 5;
	localparam int TOP_BIT   = NORM_BITS - 1;

	typedef struct packed {
		logic [2:0][31:0]          pos;
		logic [2:0][15:0]          look;
		logic [2:0][15:0]          back;
		logic [31:0]               trz;
		logic [2:0]                neg;
		logic                      zero;
		logic [2:0][NORM_BITS-1:0] m;
	} side_t;

	logic            adv;
	logic [NSTG-1:0] vld_q;

	assign adv       = !(mat_valid && mat_stall);
	assign vec_stall = !adv;
	assign mat_valid = vld_q[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], vec_valid};
		end
	end

	// Stage 1: cross product terms, look times position, negated look.
	logic signed [31:0] pos_s1 [3];
	logic signed [15:0] look_s1 [3];
	logic signed [15:0] back_s1 [3];
	logic signed [31:0] prd_s1 [6];
	logic signed [47:0] lp_s1 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			pos_s1[0]  <= vec.pos_x;
			pos_s1[1]  <= vec.pos_y;
			pos_s1[2]  <= vec.pos_z;
			look_s1[0] <= vec.look_x;
			look_s1[1] <= vec.look_y;
			look_s1[2] <= vec.look_z;
			back_s1[0] <= sat16(-64'(vec.look_x));
			back_s1[1] <= sat16(-64'(vec.look_y));
			back_s1[2] <= sat16(-64'(vec.look_z));
			prd_s1[0]  <= vec.look_y * vec.up_z;
			prd_s1[1]  <= vec.look_z * vec.up_y;
			prd_s1[2]  <= vec.look_z * vec.up_x;
			prd_s1[3]  <= vec.look_x * vec.up_z;
			prd_s1[4]  <= vec.look_x * vec.up_y;
			prd_s1[5]  <= vec.look_y * vec.up_x;
			lp_s1[0]   <= 48'(vec.look_x) * 48'(vec.pos_x);
			lp_s1[1]   <= 48'(vec.look_y) * 48'(vec.pos_y);
			lp_s1[2]   <= 48'(vec.look_z) * 48'(vec.pos_z);
		end
	end

	// Stage 2: cross product magnitudes and the look translation.
	side_t       side_s2;
	logic [31:0] mag_s2 [3];
	logic signed [32:0] crs_c [3];
	logic signed [63:0] trz_c;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			crs_c[i] = 33'(prd_s1[2*i]) - 33'(prd_s1[2*i+1]);
		end
		trz_c = rnd_shr(64'(lp_s1[0]) + 64'(lp_s1[1]) + 64'(lp_s1[2]));
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				side_s2.pos[i]  <= pos_s1[i];
				side_s2.look[i] <= look_s1[i];
				side_s2.back[i] <= back_s1[i];
				side_s2.neg[i]  <= crs_c[i][32];
				side_s2.m[i]    <= '0;
				mag_s2[i]       <= crs_c[i][32] ? 32'(-crs_c[i]) : 32'(crs_c[i]);
			end
			side_s2.trz  <= sat32(trz_c);
			side_s2.zero <= 1'b0;
		end
	end

	// Stage 3: leading one of the largest magnitude.
	side_t       side_s3;
	logic [31:0] mag_s3 [3];
	logic [4:0]  msb_s3;
	logic [31:0] mor_c;
	logic [4:0]  msb_c;
	side_t       side3_c;

	always_comb begin
		mor_c = mag_s2[0] | mag_s2[1] | mag_s2[2];
		msb_c = '0;
		for (int i = 0; i < 32; i++) begin
			if (mor_c[i]) begin
				msb_c = 5'(i);
			end
		end
		side3_c      = side_s2;
		side3_c.zero = (mor_c == '0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= side3_c;
			mag_s3  <= mag_s2;
			msb_s3  <= msb_c;
		end
	end

	// Stage 4: common shift that puts the leading one at bit 19.
	side_t side_s4;
	side_t side4_c;

	always_comb begin
		side4_c = side_s3;
		for (int i = 0; i < 3; i++) begin
			if (msb_s3 >= 5'(TOP_BIT)) begin
				side4_c.m[i] = NORM_BITS'(mag_s3[i] >> (msb_s3 - 5'(TOP_BIT)));
			end else begin
				side4_c.m[i] = NORM_BITS'(mag_s3[i] << (5'(TOP_BIT) - msb_s3));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s4 <= side4_c;
		end
	end

	// Stage 5: squares.
	side_t                    side_s5;
	logic [2*NORM_BITS-1:0]   sq_s5 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s5 <= side_s4;
			for (int i = 0; i < 3; i++) begin
				sq_s5[i] <= side_s4.m[i] * side_s4.m[i];
			end
		end
	end

	// Square root: stage 0 holds the sum of squares, then three steps a stage.
	side_t                sq_side_s [SQ_STG+1];
	logic [REM_W-1:0]     sq_rem_s  [SQ_STG+1];
	logic [ROOT_BITS-1:0] sq_root_s [SQ_STG+1];
	logic [RAD_W-1:0]     sq_rad_s  [SQ_STG+1];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_side_s[0] <= side_s5;
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_rad_s[0]  <= RAD_W'(sq_s5[0]) + RAD_W'(sq_s5[1]) + RAD_W'(sq_s5[2]);
		end
	end

	for (genvar k = 0; k < SQ_STG; k++) begin : g_sq
		logic [REM_W-1:0]     rem_c;
		logic [ROOT_BITS-1:0] root_c;
		logic [RAD_W-1:0]     rad_c;
		logic [REM_W-1:0]     trial_c;

		always_comb begin
			rem_c   = sq_rem_s[k];
			root_c  = sq_root_s[k];
			rad_c   = sq_rad_s[k];
			trial_c = '0;
			for (int j = 0; j < SQ_PER; j++) begin
				rem_c   = {rem_c[REM_W-3:0], rad_c[RAD_W-1 -: 2]};
				rad_c   = {rad_c[RAD_W-3:0], 2'b00};
				trial_c = REM_W'({root_c, 2'b01});
				if (rem_c >= trial_c) begin
					rem_c  = rem_c - trial_c;
					root_c = {root_c[ROOT_BITS-2:0], 1'b1};
				end else begin
					root_c = {root_c[ROOT_BITS-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_side_s[k+1] <= sq_side_s[k];
				sq_rem_s[k+1]  <= rem_c;
				sq_root_s[k+1] <= root_c;
				sq_rad_s[k+1]  <= rad_c;
			end
		end
	end

	// Divide: stage 0 forms the rounded numerators, then three bits a stage.
	side_t                dv_side_s [DIV_STG+1];
	logic [ROOT_BITS-1:0] dv_n_s    [DIV_STG+1];
	logic [DREM_W-1:0]    dv_rem_s  [DIV_STG+1][3];
	logic [DIV_BITS-1:0]  dv_low_s  [DIV_STG+1][3];
	logic [NUM_W-1:0]     num_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num_c[i] = (NUM_W'(sq_side_s[SQ_STG].m[i]) << DIR_FRAC_BITS)
				+ NUM_W'(sq_root_s[SQ_STG] >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dv_side_s[0] <= sq_side_s[SQ_STG];
			dv_n_s[0]    <= sq_root_s[SQ_STG];
			for (int i = 0; i < 3; i++) begin
				dv_rem_s[0][i] <= DREM_W'(num_c[i] >> DIV_BITS);
				dv_low_s[0][i] <= num_c[i][DIV_BITS-1:0];
			end
		end
	end

	for (genvar k = 0; k < DIV_STG; k++) begin : g_dv
		logic [DREM_W-1:0]   rem_c [3];
		logic [DIV_BITS-1:0] low_c [3];
		logic [DREM_W-1:0]   den_c;

		always_comb begin
			den_c = DREM_W'(dv_n_s[k]);
			for (int i = 0; i < 3; i++) begin
				rem_c[i] = dv_rem_s[k][i];
				low_c[i] = dv_low_s[k][i];
				for (int j = 0; j < DIV_PER; j++) begin
					rem_c[i] = {rem_c[i][DREM_W-2:0], low_c[i][DIV_BITS-1]};
					low_c[i] = {low_c[i][DIV_BITS-2:0], 1'b0};
					if (rem_c[i] >= den_c) begin
						rem_c[i]    = rem_c[i] - den_c;
						low_c[i][0] = 1'b1;
					end
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_side_s[k+1] <= dv_side_s[k];
				dv_n_s[k+1]    <= dv_n_s[k];
				dv_rem_s[k+1]  <= rem_c;
				dv_low_s[k+1]  <= low_c;
			end
		end
	end

	// Stage 6: signed, saturated right row.
	side_t              side_s6;
	logic signed [15:0] rt_s6 [3];
	logic signed [63:0] qv_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			qv_c[i] = $signed(64'(dv_low_s[DIV_STG][i]));
			if (dv_side_s[DIV_STG].neg[i]) begin
				qv_c[i] = -qv_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s6 <= dv_side_s[DIV_STG];
			for (int i = 0; i < 3; i++) begin
				rt_s6[i] <= dv_side_s[DIV_STG].zero ? 16'sd0 : sat16(qv_c[i]);
			end
		end
	end

	// Stage 7: right times look and right times position.
	side_t              side_s7;
	logic signed [15:0] rt_s7 [3];
	logic signed [31:0] rl_s7 [6];
	logic signed [47:0] rp_s7 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s7  <= side_s6;
			rt_s7    <= rt_s6;
			rl_s7[0] <= rt_s6[1] * $signed(side_s6.look[2]);
			rl_s7[1] <= rt_s6[2] * $signed(side_s6.look[1]);
			rl_s7[2] <= rt_s6[2] * $signed(side_s6.look[0]);
			rl_s7[3] <= rt_s6[0] * $signed(side_s6.look[2]);
			rl_s7[4] <= rt_s6[0] * $signed(side_s6.look[1]);
			rl_s7[5] <= rt_s6[1] * $signed(side_s6.look[0]);
			for (int i = 0; i < 3; i++) begin
				rp_s7[i] <= 48'(rt_s6[i]) * 48'($signed(side_s6.pos[i]));
			end
		end
	end

	// Stage 8: perpendicular up row and the right translation.
	side_t              side_s8;
	logic signed [15:0] rt_s8 [3];
	logic signed [15:0] pu_s8 [3];
	logic signed [31:0] trx_s8;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s8 <= side_s7;
			rt_s8   <= rt_s7;
			for (int i = 0; i < 3; i++) begin
				pu_s8[i] <= sat16(rnd_shr(64'(rl_s7[2*i]) - 64'(rl_s7[2*i+1])));
			end
			trx_s8 <= sat32(rnd_shr(-(64'(rp_s7[0]) + 64'(rp_s7[1]) + 64'(rp_s7[2]))));
		end
	end

	// Stage 9: perpendicular up times position.
	side_t              side_s9;
	logic signed [15:0] rt_s9 [3];
	logic signed [15:0] pu_s9 [3];
	logic signed [31:0] trx_s9;
	logic signed [47:0] pp_s9 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s9 <= side_s8;
			rt_s9   <= rt_s8;
			pu_s9   <= pu_s8;
			trx_s9  <= trx_s8;
			for (int i = 0; i < 3; i++) begin
				pp_s9[i] <= 48'(pu_s8[i]) * 48'($signed(side_s8.pos[i]));
			end
		end
	end

	// Output register.
	lvm_mat_t mat_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			mat_q.right_x   <= rt_s9[0];
			mat_q.right_y   <= rt_s9[1];
			mat_q.right_z   <= rt_s9[2];
			mat_q.perp_up_x <= pu_s9[0];
			mat_q.perp_up_y <= pu_s9[1];
			mat_q.perp_up_z <= pu_s9[2];
			mat_q.back_x    <= side_s9.back[0];
			mat_q.back_y    <= side_s9.back[1];
			mat_q.back_z    <= side_s9.back[2];
			mat_q.trans_x   <= trx_s9;
			mat_q.trans_y   <= sat32(rnd_shr(-(64'(pp_s9[0]) + 64'(pp_s9[1])
				+ 64'(pp_s9[2]))));
			mat_q.trans_z   <= side_s9.trz;
		end
	end

	assign mat = mat_q;

endmodule

// ===== sv/lvm_check.sv =====
// ----------------------------------------------------------------------------
// Look-at view matrix checker
// Port-level properties of the view matrix unit, bound to its top level.
// ----------------------------------------------------------------------------
module lvm_check import lvm_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     vec_valid,
	input logic     vec_stall,
	input lvm_vec_t vec,
	input logic     mat_valid,
	input logic     mat_stall,
	input lvm_mat_t mat
);

	// A held matrix beat stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && mat_stall |=> mat_valid && $stable(mat))
		else $error("matrix beat changed while stalled");

	// The vector side stalls exactly when a matrix beat is held.
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		vec_stall == (mat_valid && mat_stall))
		else $error("vector stall does not follow the output hold");

	// A zero right row forces the rows and translations built from it to zero.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid && mat.right_x == 16'sd0 && mat.right_y == 16'sd0
		&& mat.right_z == 16'sd0
		|-> mat.perp_up_x == 16'sd0 && mat.perp_up_y == 16'sd0
		&& mat.perp_up_z == 16'sd0 && mat.trans_x == 32'sd0 && mat.trans_y == 32'sd0)
		else $error("zero right row with nonzero dependent outputs");

	// The negated look saturates and never reaches the most negative value.
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		mat_valid |-> mat.back_x != 16'sh8000 && mat.back_y != 16'sh8000
		&& mat.back_z != 16'sh8000)
		else $error("back row not saturated");

endmodule

bind look_at_view_matrix lvm_check u_lvm_check (.*);
